### rtl/pl0ts_pkg.sv
// ----------------------------------------------------------------------------
// pl0ts_pkg
// Shared types, codes and keyword tables for the PL/0 token scanner.
// ----------------------------------------------------------------------------
package pl0ts_pkg;

    // Payload widths
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 5;
    localparam int LINE_W  = 16;
    localparam int START_W = 16;
    localparam int LEN_W   = 8;

    // Default width of the stream offset counter
    localparam int POSITION_WIDTH_DEF = 16;

    // Result queue depth; one character can produce two tokens
    localparam int RESULT_FIFO_DEPTH = 4;

    // Token kinds
    typedef enum logic [KIND_W-1:0] {
        TK_EOF          = 5'd0,
        TK_NUMBER       = 5'd1,
        TK_IDENT        = 5'd2,
        TK_KW_CONST     = 5'd3,
        TK_KW_VAR       = 5'd4,
        TK_KW_PROCEDURE = 5'd5,
        TK_KW_CALL      = 5'd6,
        TK_KW_BEGIN     = 5'd7,
        TK_KW_END       = 5'd8,
        TK_KW_IF        = 5'd9,
        TK_KW_THEN      = 5'd10,
        TK_KW_WHILE     = 5'd11,
        TK_KW_DO        = 5'd12,
        TK_KW_ODD       = 5'd13,
        TK_ASSIGN       = 5'd14,
        TK_SYMBOL       = 5'd15,
        TK_BAD_CHAR     = 5'd16,
        TK_OPEN_COMMENT = 5'd17
    } token_kind_t;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_COLON,
        MODE_COMMENT
    } scan_mode_t;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_EQUAL      = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;

    // Keyword table, right-justified strings
    localparam int KW_COUNT   = 11;
    localparam int KW_MAX_LEN = 9;
    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "const", "var", "procedure", "call", "begin", "end",
        "if", "then", "while", "do", "odd"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3
    };

    // One result transaction
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  sym;
        logic [LINE_W-1:0]  line;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               last;
    } token_t;

    // Results of one character, packed to the front
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } scan_result_t;

    // Drop keywords that no longer match at character position pos
    function automatic logic [KW_COUNT-1:0] narrow_candidates(
        input logic [KW_COUNT-1:0] cand,
        input logic [LEN_W-1:0]    pos,
        input logic [CHAR_W-1:0]   c
    );
        logic [KW_COUNT-1:0] res;
        logic [3:0]          idx;
        res = cand;
        idx = '0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (pos >= LEN_W'(KW_LEN[i]))
            begin
                res[i] = 1'b0;
            end
            else
            begin
                idx = KW_LEN[i] - 4'd1 - pos[3:0];
                if (KW_TEXT[i][8*idx +: 8] != c)
                begin
                    res[i] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // Kind of a finished identifier; a surviving keyword of equal length wins
    function automatic logic [KIND_W-1:0] keyword_kind(
        input logic [KW_COUNT-1:0] cand,
        input logic [LEN_W-1:0]    len
    );
        logic [KIND_W-1:0] kind;
        kind = TK_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (cand[i] && len == LEN_W'(KW_LEN[i]))
            begin
                kind = TK_KW_CONST + KIND_W'(i);
            end
        end
        return kind;
    endfunction

endpackage

### rtl/pl0ts_ifs.sv
// ----------------------------------------------------------------------------
// pl0ts_ifs
// Valid/ready channel interfaces: characters in, tokens out, configuration.
// ----------------------------------------------------------------------------
interface pl0ts_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface pl0ts_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [7:0]  symbol_char;
    logic [15:0] token_line;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output symbol_char,
                    output token_line, output token_start, output token_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input symbol_char,
                    input token_line, input token_start, input token_length,
                    input last_of_run, output ready);
endinterface

interface pl0ts_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_line;

    modport source (output valid, output first_line, input ready);
    modport sink   (input valid, input first_line, output ready);
endinterface

### rtl/pl0ts_in_stage.sv
// ----------------------------------------------------------------------------
// pl0ts_in_stage
// Input register for the character stream.
// ----------------------------------------------------------------------------
module pl0ts_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    pl0ts_char_if.sink              chars,
    input  logic                    take,
    output logic                    item_valid,
    output logic [pl0ts_pkg::CHAR_W-1:0] item_char
);
    import pl0ts_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              load;

    // Accept when empty or when the held character moves on this cycle
    assign chars.ready = !valid_reg || take;
    assign load        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= chars.char_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_char  = char_reg;

endmodule

### rtl/pl0ts_scan_core.sv
// ----------------------------------------------------------------------------
// pl0ts_scan_core
// Scanner state and per-character token logic; up to two tokens per char.
// ----------------------------------------------------------------------------
module pl0ts_scan_core #(
    parameter int POSITION_WIDTH = pl0ts_pkg::POSITION_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [pl0ts_pkg::CHAR_W-1:0]  c,
    input  logic                          cfg_write,
    input  logic [pl0ts_pkg::LINE_W-1:0]  cfg_first_line,
    output pl0ts_pkg::scan_result_t       result
);
    import pl0ts_pkg::*;

    scan_mode_t            mode_reg,  mode_next;
    logic [KW_COUNT-1:0]   cand_reg,  cand_next;
    logic [LEN_W-1:0]      len_reg,   len_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_next;
    logic [LINE_W-1:0]     line_reg,  line_next;
    logic [POSITION_WIDTH-1:0] pos_reg,   pos_next;
    logic [LINE_W-1:0]     first_line_reg;

    logic is_digit, is_alpha, is_blank, is_symbol;
    logic pass_on, restarted;
    logic a_vld, b_vld;
    token_t tok_a, tok_b;
    logic [LEN_W-1:0]  len_inc;
    logic [LINE_W-1:0] line_inc;
    logic [START_W-1:0] start16, pos16;

    function automatic token_t make_token(
        input logic [KIND_W-1:0]  kind,
        input logic [CHAR_W-1:0]  sym,
        input logic [LINE_W-1:0]  line,
        input logic [START_W-1:0] start,
        input logic [LEN_W-1:0]   len
    );
        token_t t;
        t.kind  = kind;
        t.sym   = sym;
        t.line  = line;
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        return t;
    endfunction

    // Character classes
    assign is_digit  = (c >= "0") && (c <= "9");
    assign is_alpha  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
                       (c == CH_UNDERSCORE);
    assign is_blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    assign is_symbol = (c == ".") || (c == "=") || (c == ",") || (c == ";") ||
                       (c == "#") || (c == "<") || (c == ">") || (c == "+") ||
                       (c == "-") || (c == "*") || (c == "/") || (c == "(") ||
                       (c == ")");

    // Saturating counters and 16-bit views of offsets
    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + 1'b1;
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign start16  = START_W'(start_reg);
    assign pos16    = START_W'(pos_reg);

    // Next state and tokens for the held character
    always_comb
    begin
        mode_next  = mode_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        start_next = start_reg;
        line_next  = line_reg;
        pass_on    = 1'b0;
        restarted  = 1'b0;
        a_vld      = 1'b0;
        b_vld      = 1'b0;
        tok_a      = make_token(TK_EOF, CH_NUL, line_reg, start16, len_reg);
        tok_b      = make_token(TK_EOF, CH_NUL, line_reg, pos16, '0);

        // Finish or extend the pending token
        case (mode_reg)
            MODE_COMMENT:
            begin
                if (c == CH_NUL)
                begin
                    a_vld     = 1'b1;
                    tok_a     = make_token(TK_OPEN_COMMENT, CH_LBRACE, line_reg,
                                           start16, len_reg);
                    b_vld     = 1'b1;
                    restarted = 1'b1;
                end
                else
                begin
                    len_next = len_inc;
                    if (c == CH_LF)
                    begin
                        line_next = line_inc;
                    end
                    if (c == CH_RBRACE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    len_next = len_inc;
                end
                else
                begin
                    a_vld   = 1'b1;
                    tok_a   = make_token(TK_NUMBER, CH_NUL, line_reg, start16, len_reg);
                    pass_on = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha || is_digit)
                begin
                    cand_next = narrow_candidates(cand_reg, len_reg, c);
                    len_next  = len_inc;
                end
                else
                begin
                    a_vld   = 1'b1;
                    tok_a   = make_token(keyword_kind(cand_reg, len_reg), CH_NUL,
                                         line_reg, start16, len_reg);
                    pass_on = 1'b1;
                end
            end
            MODE_COLON:
            begin
                if (c == CH_EQUAL)
                begin
                    a_vld     = 1'b1;
                    tok_a     = make_token(TK_ASSIGN, CH_NUL, line_reg, start16, 8'd2);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    a_vld   = 1'b1;
                    tok_a   = make_token(TK_BAD_CHAR, CH_COLON, line_reg, start16, 8'd1);
                    pass_on = 1'b1;
                end
            end
            default:
            begin
                pass_on = 1'b1;
            end
        endcase

        // Scan the character from the idle state
        if (pass_on)
        begin
            mode_next = MODE_IDLE;
            cand_next = KW_ALL;
            len_next  = '0;
            if (c == CH_NUL)
            begin
                b_vld     = 1'b1;
                restarted = 1'b1;
            end
            else if (c == CH_LF)
            begin
                line_next = line_inc;
            end
            else if (is_blank)
            begin
                line_next = line_reg;
            end
            else if (c == CH_LBRACE)
            begin
                mode_next  = MODE_COMMENT;
                start_next = pos_reg;
                len_next   = 8'd1;
            end
            else if (is_digit)
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = 8'd1;
            end
            else if (is_alpha)
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                cand_next  = narrow_candidates(KW_ALL, '0, c);
                len_next   = 8'd1;
            end
            else if (c == CH_COLON)
            begin
                mode_next  = MODE_COLON;
                start_next = pos_reg;
                len_next   = 8'd1;
            end
            else if (is_symbol)
            begin
                b_vld = 1'b1;
                tok_b = make_token(TK_SYMBOL, c, line_reg, pos16, 8'd1);
            end
            else
            begin
                b_vld = 1'b1;
                tok_b = make_token(TK_BAD_CHAR, c, line_reg, pos16, 8'd1);
            end
        end

        // End of input starts a new stream
        if (restarted)
        begin
            mode_next  = MODE_IDLE;
            cand_next  = KW_ALL;
            len_next   = '0;
            start_next = '0;
            line_next  = first_line_reg;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end

        // Pack tokens to the front and mark the last one
        result.count  = {1'b0, a_vld} + {1'b0, b_vld};
        result.first  = a_vld ? tok_a : tok_b;
        result.second = tok_b;
        result.first.last  = !(a_vld && b_vld);
        result.second.last = 1'b1;
    end

    // State registers; configuration is to come only while idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            cand_reg       <= KW_ALL;
            len_reg        <= '0;
            start_reg      <= '0;
            line_reg       <= '0;
            pos_reg        <= '0;
            first_line_reg <= '0;
        end
        else if (cfg_write)
        begin
            first_line_reg <= cfg_first_line;
            line_reg       <= cfg_first_line;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            cand_reg  <= cand_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

### rtl/pl0ts_result_fifo.sv
// ----------------------------------------------------------------------------
// pl0ts_result_fifo
// Token queue: takes up to two tokens per cycle, gives one per transaction.
// ----------------------------------------------------------------------------
module pl0ts_result_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pl0ts_pkg::scan_result_t result,
    output logic                    room_for_two,
    pl0ts_token_if.source           tokens
);
    import pl0ts_pkg::*;

    localparam int PTR_W = $clog2(RESULT_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RESULT_FIFO_DEPTH + 1);

    token_t            mem [RESULT_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [1:0]        push_n;
    logic              pop;
    token_t            head;

    assign push_n       = push ? result.count : 2'd0;
    assign pop          = tokens.valid && tokens.ready;
    assign room_for_two = (count_reg <= CNT_W'(RESULT_FIFO_DEPTH - 2));

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= result.first;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + 1'b1] <= result.second;
        end
    end

    // Head of queue drives the output channel
    assign head                = mem[rd_ptr_reg];
    assign tokens.valid        = (count_reg != '0);
    assign tokens.token_kind   = head.kind;
    assign tokens.symbol_char  = head.sym;
    assign tokens.token_line   = head.line;
    assign tokens.token_start  = head.start;
    assign tokens.token_length = head.len;
    assign tokens.last_of_run  = head.last;

endmodule

### rtl/pl0_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// pl0_token_scanner_unit
// Streaming PL/0 lexer: one ASCII character per transaction in, tokens out.
// ----------------------------------------------------------------------------
// A character can be accepted every clock cycle while two result queue slots
// are free. Each accepted character is held in the input register, then the
// scanner logic updates its state and writes zero, one or two tokens into a
// four-entry result queue whose head drives the output.
// The output gives one token per cycle while the sink is ready, so
// throughput is one character per cycle while the tokens produced do not
// outrun one per cycle; the input stalls only when the result queue has fewer
// than two free slots. A token is emitted
// when the character that ends it arrives; a 0 character ends the stream,
// emits any pending token followed by eof, and restarts offsets and line
// count. Writing first_line also reloads the line count; write it only while
// no characters are in flight.
// ----------------------------------------------------------------------------
module pl0_token_scanner_unit #(
    parameter int POSITION_WIDTH = pl0ts_pkg::POSITION_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pl0ts_char_if.sink    chars,
    pl0ts_token_if.source tokens,
    pl0ts_cfg_if.sink     cfg
);
    import pl0ts_pkg::*;

    logic              item_valid;
    logic [CHAR_W-1:0] item_char;
    logic              room_for_two;
    logic              take;
    logic              cfg_write;
    scan_result_t      result;

    // Control: move a character into the scanner when two queue slots are free
    assign take      = item_valid && room_for_two;
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    pl0ts_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .take       (take),
        .item_valid (item_valid),
        .item_char  (item_char)
    );

    pl0ts_scan_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scan_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (take),
        .c              (item_char),
        .cfg_write      (cfg_write),
        .cfg_first_line (cfg.first_line),
        .result         (result)
    );

    pl0ts_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (take),
        .result       (result),
        .room_for_two (room_for_two),
        .tokens       (tokens)
    );

endmodule

### rtl/pl0ts_checker.sv
// ----------------------------------------------------------------------------
// pl0ts_checker
// Port-level checks on the token output of the scanner.
// ----------------------------------------------------------------------------
module pl0ts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [4:0]  tok_kind,
    input logic [7:0]  tok_sym,
    input logic [7:0]  tok_len,
    input logic        tok_last
);
    import pl0ts_pkg::*;

    // eof always closes the run of its character and has no length or symbol
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind == TK_EOF |-> tok_last && tok_len == 8'd0 &&
        tok_sym == CH_NUL)
        else $error("eof token malformed");

    // every token other than eof covers at least one character
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind != TK_EOF |-> tok_len != 8'd0)
        else $error("zero-length token");

    // numbers, identifiers, keywords and assign carry no symbol character
    a_no_sym: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind >= TK_NUMBER && tok_kind <= TK_ASSIGN |->
        tok_sym == CH_NUL)
        else $error("unexpected symbol character");

    // a stalled transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) &&
        $stable(tok_sym) && $stable(tok_len) && $stable(tok_last))
        else $error("output changed while stalled");

endmodule

bind pl0_token_scanner_unit pl0ts_checker u_pl0ts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tokens.valid),
    .tok_ready (tokens.ready),
    .tok_kind  (tokens.token_kind),
    .tok_sym   (tokens.symbol_char),
    .tok_len   (tokens.token_length),
    .tok_last  (tokens.last_of_run)
);

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PL/0 token scanner unit. A driver feeds
// characters from a queue, a predictor lexes every accepted character on its
// own and queues the tokens it should produce, and a monitor compares each
// token transaction field by field against the oldest prediction. Both sides
// idle at random; first_line is rewritten between quiet phases.
// ----------------------------------------------------------------------------
module tb_top;

    import pl0ts_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 100;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_CHARS   = 225;
    localparam int KEYWORDS      = 11;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pl0ts_char_if  char_ch ();
    pl0ts_token_if token_ch ();
    pl0ts_cfg_if   cfg_ch ();

    pl0_token_scanner_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_ch),
        .tokens (token_ch),
        .cfg    (cfg_ch)
    );

    // Keyword spellings in token kind order
    string kw_word [KEYWORDS] = '{"const", "var", "procedure", "call", "begin", "end",
                                  "if", "then", "while", "do", "odd"};
    string sym_set   = ".=,;#<>+-*/()";
    string blank_set = " \t\r\n";

    // Character stream waiting to be sent, and tokens predicted but not yet seen
    logic [CHAR_W-1:0] source_text [$];
    token_t            tokens_due [$];
    token_t            step_tokens [$];

    int unsigned chars_queued = 0;
    int unsigned chars_lexed  = 0;
    int unsigned phase_chars  = 0;
    int unsigned fail_count   = 0;
    int unsigned source_idle_pct = 0;
    int unsigned sink_idle_pct   = 0;
    int unsigned char_gap    = 0;
    int unsigned token_stall = 0;
    int unsigned quiet_cycles = 0;

    // Lexer state of the predictor
    scan_mode_t          sc_mode;
    logic [KW_COUNT-1:0] kw_live;
    logic [LEN_W-1:0]    tok_len;
    logic [START_W-1:0]  tok_start;
    logic [LINE_W-1:0]   line_no;
    logic [START_W-1:0]  char_pos;
    logic [LINE_W-1:0]   cfg_first_line;

    // Clock, 10 ns period
    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
    endfunction

    function automatic bit is_symbol(input logic [7:0] c);
        for (int i = 0; i < sym_set.len(); i++)
        begin
            if (c == sym_set[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_scan();
        sc_mode   = MODE_IDLE;
        kw_live   = '1;
        tok_len   = '0;
        tok_start = '0;
        line_no   = cfg_first_line;
        char_pos  = '0;
    endfunction

    function automatic void add_token(input logic [KIND_W-1:0] kind, input logic [7:0] sym,
                                      input logic [START_W-1:0] start,
                                      input logic [LEN_W-1:0] len);
        token_t t;
        if (step_tokens.size() >= 2)
            return;
        t.kind  = kind;
        t.sym   = sym;
        t.line  = line_no;
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void bump_len();
        if (tok_len != 8'hFF)
            tok_len = tok_len + 1'b1;
    endfunction

    function automatic void bump_line();
        if (line_no != 16'hFFFF)
            line_no = line_no + 1'b1;
    endfunction

    // Drop keywords whose spelling differs at the current length
    function automatic void narrow_keywords(input logic [7:0] c);
        for (int i = 0; i < KEYWORDS; i++)
        begin
            if (kw_live[i] && (tok_len >= kw_word[i].len() || kw_word[i][tok_len] != c))
                kw_live[i] = 1'b0;
        end
    endfunction

    function automatic void open_token(input scan_mode_t mode);
        sc_mode   = mode;
        tok_start = char_pos;
        tok_len   = 8'd1;
    endfunction

    // Character seen between tokens; returns 1 when it ended the stream
    function automatic bit scan_fresh(input logic [7:0] c);
        sc_mode = MODE_IDLE;
        kw_live = '1;
        tok_len = '0;
        if (c == CH_NUL)
        begin
            add_token(TK_EOF, CH_NUL, char_pos, '0);
            reset_scan();
            return 1'b1;
        end
        if (c == CH_LF)
            bump_line();
        else if (c == CH_LBRACE)
            open_token(MODE_COMMENT);
        else if (is_digit(c))
            open_token(MODE_NUMBER);
        else if (is_word_start(c))
        begin
            narrow_keywords(c);
            open_token(MODE_IDENT);
        end
        else if (c == CH_COLON)
            open_token(MODE_COLON);
        else if (is_symbol(c))
            add_token(TK_SYMBOL, c, char_pos, 8'd1);
        else if (!is_blank(c))
            add_token(TK_BAD_CHAR, c, char_pos, 8'd1);
        return 1'b0;
    endfunction

    // Lex one accepted character and queue the tokens it completes
    function automatic void lex_char(input logic [7:0] c);
        bit                flushed;
        bit                ended;
        logic [KIND_W-1:0] kind;
        token_t            t;
        step_tokens.delete();
        flushed = 1'b0;
        ended   = 1'b0;
        case (sc_mode)
            MODE_COMMENT:
            begin
                if (c == CH_NUL)
                begin
                    add_token(TK_OPEN_COMMENT, CH_LBRACE, tok_start, tok_len);
                    add_token(TK_EOF, CH_NUL, char_pos, '0);
                    reset_scan();
                    ended = 1'b1;
                end
                else
                begin
                    bump_len();
                    if (c == CH_LF)
                        bump_line();
                    if (c == CH_RBRACE)
                        sc_mode = MODE_IDLE;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(c))
                    bump_len();
                else
                begin
                    add_token(TK_NUMBER, CH_NUL, tok_start, tok_len);
                    flushed = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_word_start(c) || is_digit(c))
                begin
                    narrow_keywords(c);
                    bump_len();
                end
                else
                begin
                    // a surviving keyword of exactly this length wins
                    kind = TK_IDENT;
                    for (int i = 0; i < KEYWORDS; i++)
                    begin
                        if (kw_live[i] && tok_len == kw_word[i].len())
                            kind = TK_KW_CONST + KIND_W'(i);
                    end
                    add_token(kind, CH_NUL, tok_start, tok_len);
                    flushed = 1'b1;
                end
            end
            MODE_COLON:
            begin
                if (c == CH_EQUAL)
                begin
                    add_token(TK_ASSIGN, CH_NUL, tok_start, 8'd2);
                    sc_mode = MODE_IDLE;
                end
                else
                begin
                    // lone colon
                    add_token(TK_BAD_CHAR, CH_COLON, tok_start, 8'd1);
                    flushed = 1'b1;
                end
            end
            default:
                flushed = 1'b1;
        endcase
        if (flushed)
            ended = scan_fresh(c);
        if (!ended)
            char_pos = char_pos + 1'b1;
        for (int i = 0; i < step_tokens.size(); i++)
        begin
            t = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            tokens_due.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap(input int unsigned idle_pct);
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic void push_char(input logic [7:0] c);
        source_text.push_back(c);
        chars_queued++;
        phase_chars++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    function automatic logic [7:0] word_start();
        case ($urandom_range(4))
            0:       return CH_UNDERSCORE;
            1:       return 8'("A" + $urandom_range(25));
            default: return 8'("a" + $urandom_range(25));
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        if ($urandom_range(3) == 0)
            return 8'("0" + $urandom_range(9));
        return word_start();
    endfunction

    // Anything but the closing brace or the end mark
    function automatic logic [7:0] comment_char();
        logic [7:0] c;
        c = 8'($urandom_range(255, 1));
        if (c == CH_RBRACE)
            c = CH_LF;
        return c;
    endfunction

    // One lexical fragment: mostly well-formed PL/0, some noise
    function automatic void push_fragment();
        int unsigned pick;
        int unsigned k;
        int unsigned n;
        int unsigned tweak;
        logic [7:0]  c;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            // keyword, now and then cut short, capitalized or extended
            k     = $urandom_range(KEYWORDS - 1);
            tweak = $urandom_range(9);
            n     = kw_word[k].len();
            if (tweak == 0)
                n = $urandom_range(n - 1, 1);
            for (int i = 0; i < n; i++)
            begin
                c = kw_word[k][i];
                if (tweak == 1 && i == n - 1)
                    c = c - 8'd32;
                push_char(c);
            end
            if (tweak == 2)
                push_char(word_char());
        end
        else if (pick < 35)
        begin
            push_char(word_start());
            repeat ($urandom_range(7))
                push_char(word_char());
        end
        else if (pick < 47)
        begin
            repeat ($urandom_range(6, 1))
                push_char(8'("0" + $urandom_range(9)));
        end
        else if (pick < 62)
            push_char(sym_set[$urandom_range(sym_set.len() - 1)]);
        else if (pick < 67)
            push_text(":=");
        else if (pick < 69)
            push_char(CH_COLON);
        else if (pick < 79)
        begin
            repeat ($urandom_range(3, 1))
                push_char(blank_set[$urandom_range(3)]);
        end
        else if (pick < 85)
        begin
            push_char(CH_LBRACE);
            repeat ($urandom_range(12))
                push_char(comment_char());
            push_char(CH_RBRACE);
        end
        else if (pick < 90)
            push_char(8'($urandom_range(255, 1)));
        else if (pick < 92)
            push_char(CH_NUL);
        else if (pick < 93)
        begin
            // comment left open at end of stream
            push_char(CH_LBRACE);
            repeat ($urandom_range(5))
                push_char(comment_char());
            push_char(CH_NUL);
        end
        else if (pick < 94)
        begin
            // long token to reach length saturation
            n = $urandom_range(300, 250);
            case ($urandom_range(2))
                0:
                begin
                    push_char(word_start());
                    repeat (n)
                        push_char(word_char());
                end
                1:
                begin
                    repeat (n)
                        push_char(8'("0" + $urandom_range(9)));
                end
                default:
                begin
                    push_char(CH_LBRACE);
                    repeat (n)
                        push_char(comment_char());
                    push_char(CH_RBRACE);
                end
            endcase
        end
        else
            push_char(CH_SPACE);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            if (fail_count < REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Wait until every queued character is lexed and every token has come out
    task automatic wait_drained();
        @(posedge clk);
        while (chars_lexed != chars_queued || tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write while the scanner is quiet; it also reloads the line count
    task automatic write_first_line(input logic [LINE_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.first_line <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid   <= 1'b0;
        cfg_first_line = value;
        line_no        = value;
    endtask

    // ------------------------------------------------------------------
    // Character driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        int unsigned gap;
        if (!rst_n)
        begin
            char_ch.valid     <= 1'b0;
            char_ch.char_byte <= '0;
            char_gap          <= 0;
        end
        else
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                lex_char(char_ch.char_byte);
                chars_lexed++;
            end
            if (!char_ch.valid || char_ch.ready)
            begin
                if (char_gap > 0)
                begin
                    char_gap      <= char_gap - 1;
                    char_ch.valid <= 1'b0;
                end
                else if (source_text.size() > 0)
                begin
                    gap = pick_gap(source_idle_pct);
                    if (gap > 0)
                    begin
                        char_gap      <= gap - 1;
                        char_ch.valid <= 1'b0;
                    end
                    else
                    begin
                        char_ch.valid     <= 1'b1;
                        char_ch.char_byte <= source_text.pop_front();
                    end
                end
                else
                    char_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Token monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : token_monitor
        token_t      want;
        int unsigned stall;
        if (!rst_n)
        begin
            token_ch.ready <= 1'b0;
            token_stall    <= 0;
        end
        else
        begin
            if (token_ch.valid && token_ch.ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $error("token with none predicted: kind %0d start %0d",
                               token_ch.token_kind, token_ch.token_start);
                    fail_count++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", 16'(want.kind), 16'(token_ch.token_kind));
                    check_field("symbol_char", 16'(want.sym), 16'(token_ch.symbol_char));
                    check_field("token_line", want.line, token_ch.token_line);
                    check_field("token_start", want.start, token_ch.token_start);
                    check_field("token_length", 16'(want.len),
                                16'(token_ch.token_length));
                    check_field("last_of_run", 16'(want.last),
                                16'(token_ch.last_of_run));
                end
            end
            if (token_stall > 0)
            begin
                token_stall    <= token_stall - 1;
                token_ch.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap(sink_idle_pct);
                token_stall    <= (stall > 0) ? stall - 1 : 0;
                token_ch.ready <= (stall == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((char_ch.valid && char_ch.ready) || (token_ch.valid && token_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("pl0_token_scanner_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        char_ch.valid     = 1'b0;
        char_ch.char_byte = '0;
        token_ch.ready    = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.first_line = '0;
        cfg_first_line    = '0;
        reset_scan();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ident, assign, number, symbol, lone colon, keyword, stray
        // brace, control and high bytes, blanks, then a comment left open
        source_idle_pct = 20;
        sink_idle_pct   = 20;
        push_text("_Z9 := 0;\t:odd}");
        push_char(8'h01);
        push_char(8'h80);
        push_char(8'hFF);
        push_text("\r\n{x\n");
        push_char(CH_NUL);
        wait_drained();

        // Random phases, each with its own first_line and idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       write_first_line(16'hFFFF);
                1:       write_first_line(16'h0000);
                2:       write_first_line(16'hFFFE);
                4:       write_first_line(16'h0001);
                default: write_first_line(16'($urandom));
            endcase
            source_idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(50, 5);
            sink_idle_pct   = (ph % 4 == 1) ? 0 : $urandom_range(60, 5);
            phase_chars     = 0;
            while (phase_chars < PHASE_CHARS)
                push_fragment();
            wait_drained();
        end

        // Close the last stream so any pending token comes out
        push_char(CH_NUL);
        wait_drained();

        if (fail_count == 0)
            $display("pl0_token_scanner_unit test passed");
        else
            $display("pl0_token_scanner_unit test failed");
        $finish;
    end

endmodule

### files.f
rtl/pl0ts_pkg.sv
rtl/pl0ts_ifs.sv
rtl/pl0ts_in_stage.sv
rtl/pl0ts_scan_core.sv
rtl/pl0ts_result_fifo.sv
rtl/pl0_token_scanner_unit.sv
rtl/pl0ts_checker.sv
bench/tb_top.sv
